[hdl/c6502s_pkg.sv]
`timescale 1ns / 1ps

package c6502s_pkg;

    // Program memory size; the program counter wraps modulo this (a power of two).
    localparam int unsigned ROM_BYTES = 4096;
    localparam int unsigned PC_W      = 12;
    localparam logic [PC_W-1:0] PC_MASK = PC_W'(ROM_BYTES - 1);

    localparam int unsigned ZP_DEPTH = 256;
    localparam logic [7:0]  WSYNC_ADDR = 8'h02;

    // Supported opcodes
    localparam logic [7:0] OP_CLD     = 8'hD8;
    localparam logic [7:0] OP_SEI     = 8'h78;
    localparam logic [7:0] OP_LDX_IMM = 8'hA2;
    localparam logic [7:0] OP_LDY_IMM = 8'hA0;
    localparam logic [7:0] OP_LDA_IMM = 8'hA9;
    localparam logic [7:0] OP_TXS     = 8'h9A;
    localparam logic [7:0] OP_TXA     = 8'h8A;
    localparam logic [7:0] OP_INX     = 8'hE8;
    localparam logic [7:0] OP_INY     = 8'hC8;
    localparam logic [7:0] OP_DEX     = 8'hCA;
    localparam logic [7:0] OP_DEY     = 8'h88;
    localparam logic [7:0] OP_ASL_A   = 8'h0A;
    localparam logic [7:0] OP_STA_ZP  = 8'h85;
    localparam logic [7:0] OP_STA_ZPX = 8'h95;
    localparam logic [7:0] OP_STX_ZP  = 8'h86;
    localparam logic [7:0] OP_STY_ZP  = 8'h84;
    localparam logic [7:0] OP_BNE     = 8'hD0;
    localparam logic [7:0] OP_JMP_ABS = 8'h4C;
    localparam logic [7:0] OP_CPX_IMM = 8'hE0;
    localparam logic [7:0] OP_CPY_IMM = 8'hC0;
    localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
    localparam logic [7:0] OP_INC_ZP  = 8'hE6;
    localparam logic [7:0] OP_NOP     = 8'hEA;

    typedef struct packed {
        logic [7:0]      acc;
        logic [7:0]      x;
        logic [7:0]      y;
        logic [7:0]      sp;
        logic            flag_z;
        logic            flag_d;
        logic            flag_i;
        logic [PC_W-1:0] pc;
    } t_arch;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            write_enable;
        logic [7:0]      write_address;
        logic [7:0]      write_data;
        logic            wsync_hit;
        logic            illegal_opcode;
        logic [7:0]      acc_value;
        logic [7:0]      x_value;
        logic [7:0]      y_value;
        logic            zero_flag;
    } t_result;

    // Reduce a raw address to the program space
    function automatic logic [PC_W-1:0] pc_wrap(input logic [15:0] addr);
        pc_wrap = addr[PC_W-1:0] & PC_MASK;
    endfunction

endpackage

[hdl/c6502s_zp_ram.sv]
`timescale 1ns / 1ps

module c6502s_zp_ram import c6502s_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  logic [7:0] i_rd_addr,
    input  logic       i_wr_en,
    input  logic [7:0] i_wr_addr,
    input  logic [7:0] i_wr_data,
    output logic [7:0] o_rd_data
);

    logic [7:0]          r_mem [ZP_DEPTH];
    logic [ZP_DEPTH-1:0] r_valid;
    logic [7:0]          r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Forward a write landing on the same edge as the read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= 8'h00;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/c6502s_exec.sv]
`timescale 1ns / 1ps

module c6502s_exec import c6502s_pkg::*; (
    input  t_arch      i_state,
    input  logic [7:0] i_opcode,
    input  logic [7:0] i_operand_low,
    input  logic [7:0] i_operand_high,
    input  logic [7:0] i_zp_data,
    output t_arch      o_state,
    output t_result    o_result
);

    always_comb begin
        t_arch           n_st;
        logic [1:0]      len;
        logic            jumped;
        logic            illegal;
        logic            wr;
        logic [7:0]      waddr;
        logic [7:0]      wdata;
        logic [7:0]      tmp;
        logic [PC_W-1:0] target;

        n_st    = i_state;
        len     = 2'd1;
        jumped  = 1'b0;
        illegal = 1'b0;
        wr      = 1'b0;
        waddr   = 8'h00;
        wdata   = 8'h00;
        tmp     = 8'h00;
        target  = i_state.pc;

        unique case (i_opcode)
            OP_CLD: n_st.flag_d = 1'b0;
            OP_SEI: n_st.flag_i = 1'b1;
            OP_LDX_IMM: begin
                n_st.x      = i_operand_low;
                n_st.flag_z = (i_operand_low == 8'h00);
                len         = 2'd2;
            end
            OP_LDY_IMM: begin
                n_st.y      = i_operand_low;
                n_st.flag_z = (i_operand_low == 8'h00);
                len         = 2'd2;
            end
            OP_LDA_IMM: begin
                n_st.acc    = i_operand_low;
                n_st.flag_z = (i_operand_low == 8'h00);
                len         = 2'd2;
            end
            OP_TXS: n_st.sp = i_state.x;
            OP_TXA: begin
                n_st.acc    = i_state.x;
                n_st.flag_z = (i_state.x == 8'h00);
            end
            OP_INX: begin
                tmp         = i_state.x + 8'd1;
                n_st.x      = tmp;
                n_st.flag_z = (tmp == 8'h00);
            end
            OP_INY: begin
                tmp         = i_state.y + 8'd1;
                n_st.y      = tmp;
                n_st.flag_z = (tmp == 8'h00);
            end
            OP_DEX: begin
                tmp         = i_state.x - 8'd1;
                n_st.x      = tmp;
                n_st.flag_z = (tmp == 8'h00);
            end
            OP_DEY: begin
                tmp         = i_state.y - 8'd1;
                n_st.y      = tmp;
                n_st.flag_z = (tmp == 8'h00);
            end
            OP_ASL_A: begin
                tmp         = {i_state.acc[6:0], 1'b0};
                n_st.acc    = tmp;
                n_st.flag_z = (tmp == 8'h00);
            end
            OP_STA_ZP: begin
                wr    = 1'b1;
                waddr = i_operand_low;
                wdata = i_state.acc;
                len   = 2'd2;
            end
            OP_STA_ZPX: begin
                wr    = 1'b1;
                waddr = i_operand_low + i_state.x;
                wdata = i_state.acc;
                len   = 2'd2;
            end
            OP_STX_ZP: begin
                wr    = 1'b1;
                waddr = i_operand_low;
                wdata = i_state.x;
                len   = 2'd2;
            end
            OP_STY_ZP: begin
                wr    = 1'b1;
                waddr = i_operand_low;
                wdata = i_state.y;
                len   = 2'd2;
            end
            OP_INC_ZP: begin
                tmp         = i_zp_data + 8'd1;
                wr          = 1'b1;
                waddr       = i_operand_low;
                wdata       = tmp;
                n_st.flag_z = (tmp == 8'h00);
                len         = 2'd2;
            end
            OP_LDA_ZP: begin
                n_st.acc    = i_zp_data;
                n_st.flag_z = (i_zp_data == 8'h00);
                len         = 2'd2;
            end
            OP_CPX_IMM: begin
                n_st.flag_z = (i_state.x == i_operand_low);
                len         = 2'd2;
            end
            OP_CPY_IMM: begin
                n_st.flag_z = (i_state.y == i_operand_low);
                len         = 2'd2;
            end
            OP_BNE: begin
                len = 2'd2;
                if (!i_state.flag_z) begin
                    jumped = 1'b1;
                    target = pc_wrap(16'(i_state.pc + PC_W'(2)
                                         + {{(PC_W-8){i_operand_low[7]}}, i_operand_low}));
                end
            end
            OP_JMP_ABS: begin
                jumped = 1'b1;
                target = pc_wrap({i_operand_high, i_operand_low});
            end
            OP_NOP: ;
            default: illegal = 1'b1;
        endcase

        if (illegal) begin
            n_st.pc = i_state.pc;
        end else if (jumped) begin
            n_st.pc = target;
        end else begin
            n_st.pc = pc_wrap(16'(i_state.pc + PC_W'(len)));
        end

        o_state                 = n_st;
        o_result.next_pc        = n_st.pc;
        o_result.write_enable   = wr;
        o_result.write_address  = waddr;
        o_result.write_data     = wdata;
        o_result.wsync_hit      = wr && (waddr == WSYNC_ADDR);
        o_result.illegal_opcode = illegal;
        o_result.acc_value      = n_st.acc;
        o_result.x_value        = n_st.x;
        o_result.y_value        = n_st.y;
        o_result.zero_flag      = n_st.flag_z;
    end

endmodule

[hdl/cpu6502_subset_execute_core.sv]
`timescale 1ns / 1ps
// Result path: the input transfer loads the input register, then execute writes the result
// register, from which the result transfer is taken.
// Throughput: one instruction per cycle while the result side is not stalled, set by the
// single execute pass and the registered zero-page read.
// Reset (i_rst_n low, synchronous): registers, flags and program counter go to zero,
// zero-page entries read as zero until written, both pipeline stages empty.

module cpu6502_subset_execute_core import c6502s_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // instruction channel
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_opcode,
    input  logic [7:0]      i_operand_low,
    input  logic [7:0]      i_operand_high,
    // result channel
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [PC_W-1:0] o_next_pc,
    output logic            o_write_enable,
    output logic [7:0]      o_write_address,
    output logic [7:0]      o_write_data,
    output logic            o_wsync_hit,
    output logic            o_illegal_opcode,
    output logic [7:0]      o_acc_value,
    output logic [7:0]      o_x_value,
    output logic [7:0]      o_y_value,
    output logic            o_zero_flag
);

    // Input stage
    logic       r_in_vld;
    logic [7:0] r_opcode;
    logic [7:0] r_operand_low;
    logic [7:0] r_operand_high;

    // Architectural state and result stage
    t_arch   r_arch;
    t_arch   n_arch;
    t_result n_result;
    t_result r_result;
    logic    r_out_vld;

    logic       in_xfer;
    logic       exec_go;
    logic [7:0] zp_data;

    // Execute when an instruction waits and the result register is free or being drained this cycle.
    assign exec_go    = r_in_vld && (!r_out_vld || i_out_ready);
    // The input stage takes a new transfer whenever it is empty or advancing.
    assign o_in_ready = !r_in_vld || exec_go;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (exec_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_opcode       <= i_opcode;
            r_operand_low  <= i_operand_low;
            r_operand_high <= i_operand_high;
        end
    end

    // Zero-page read is launched on transfer, addressed by the operand byte, so the
    // data is ready when the instruction reaches execute. A write from the instruction
    // executing on that same edge is forwarded inside the RAM; no other write can
    // intervene while the instruction waits in the input stage.
    c6502s_zp_ram u_zp_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_xfer),
        .i_rd_addr (i_operand_low),
        .i_wr_en   (exec_go && n_result.write_enable),
        .i_wr_addr (n_result.write_address),
        .i_wr_data (n_result.write_data),
        .o_rd_data (zp_data)
    );

    c6502s_exec u_exec (
        .i_state        (r_arch),
        .i_opcode       (r_opcode),
        .i_operand_low  (r_operand_low),
        .i_operand_high (r_operand_high),
        .i_zp_data      (zp_data),
        .o_state        (n_arch),
        .o_result       (n_result)
    );

    // Commit state only when the instruction leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch <= '0;
        end else if (exec_go) begin
            r_arch <= n_arch;
        end
    end

    // Result register: load on execute, drop after the output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec_go) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_next_pc        = r_result.next_pc;
    assign o_write_enable   = r_result.write_enable;
    assign o_write_address  = r_result.write_address;
    assign o_write_data     = r_result.write_data;
    assign o_wsync_hit      = r_result.wsync_hit;
    assign o_illegal_opcode = r_result.illegal_opcode;
    assign o_acc_value      = r_result.acc_value;
    assign o_x_value        = r_result.x_value;
    assign o_y_value        = r_result.y_value;
    assign o_zero_flag      = r_result.zero_flag;

endmodule

[hdl/c6502s_checker.sv]
`timescale 1ns / 1ps

module c6502s_checker import c6502s_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [PC_W-1:0] o_next_pc,
    input logic            o_write_enable,
    input logic [7:0]      o_write_address,
    input logic [7:0]      o_write_data,
    input logic            o_wsync_hit,
    input logic            o_illegal_opcode,
    input logic [7:0]      o_acc_value,
    input logic [7:0]      o_x_value,
    input logic [7:0]      o_y_value,
    input logic            o_zero_flag
);

    // No result survives reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_next_pc)
            && $stable(o_acc_value) && $stable(o_write_data)
            && $stable(o_write_enable) && $stable(o_write_address)
            && $stable(o_wsync_hit) && $stable(o_illegal_opcode)
            && $stable(o_x_value) && $stable(o_y_value) && $stable(o_zero_flag))
        else $error("stalled result changed");

    // With no result waiting the input side is always open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with result register empty");

    // Wsync flag only with a write to address two
    a_wsync_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_wsync_hit |-> o_write_enable && (o_write_address == WSYNC_ADDR))
        else $error("wsync without write to its address");

    // Illegal opcode never writes and reports no write fields
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_illegal_opcode |-> !o_write_enable && !o_wsync_hit
            && (o_write_address == 8'h00) && (o_write_data == 8'h00))
        else $error("illegal opcode produced a write");

endmodule

bind cpu6502_subset_execute_core c6502s_checker u_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import c6502s_pkg::*;

    // Supported opcodes, used to draw well-formed instructions at random
    localparam logic [7:0] LEGAL_OPS [23] = '{
        OP_CLD, OP_SEI, OP_LDX_IMM, OP_LDY_IMM, OP_LDA_IMM, OP_TXS, OP_TXA, OP_INX,
        OP_INY, OP_DEX, OP_DEY, OP_ASL_A, OP_STA_ZP, OP_STA_ZPX, OP_STX_ZP, OP_STY_ZP,
        OP_BNE, OP_JMP_ABS, OP_CPX_IMM, OP_CPY_IMM, OP_LDA_ZP, OP_INC_ZP, OP_NOP
    };
    localparam int unsigned REPORT_LIMIT = 10;

    logic            i_clk          = 1'b0;
    logic            i_rst_n        = 1'b0;
    logic            i_in_valid     = 1'b0;
    logic [7:0]      i_opcode       = 8'h00;
    logic [7:0]      i_operand_low  = 8'h00;
    logic [7:0]      i_operand_high = 8'h00;
    logic            i_out_ready    = 1'b0;
    logic            o_in_ready;
    logic            o_out_valid;
    logic [PC_W-1:0] o_next_pc;
    logic            o_write_enable;
    logic [7:0]      o_write_address;
    logic [7:0]      o_write_data;
    logic            o_wsync_hit;
    logic            o_illegal_opcode;
    logic [7:0]      o_acc_value;
    logic [7:0]      o_x_value;
    logic [7:0]      o_y_value;
    logic            o_zero_flag;

    // Architectural state as the testbench believes it after the last accepted transfer
    logic [7:0]      arch_acc;
    logic [7:0]      arch_x;
    logic [7:0]      arch_y;
    logic [7:0]      arch_sp;
    logic            arch_flag_z;
    logic            arch_flag_d;
    logic            arch_flag_i;
    logic [PC_W-1:0] arch_pc;
    logic [7:0]      arch_zp [ZP_DEPTH];

    // Results still owed by the block, oldest first
    t_result         pending_results [$];

    bit              idle_on       = 1'b1;
    int unsigned     sink_hold_req = 0;
    int unsigned     n_issued      = 0;
    int unsigned     n_retired     = 0;
    int unsigned     n_errors      = 0;
    int unsigned     n_illegal     = 0;
    int unsigned     n_taken       = 0;
    int unsigned     n_wsync       = 0;
    int unsigned     n_in_stalls   = 0;

    cpu6502_subset_execute_core DUT (.*);

    always #10 i_clk = ~i_clk;

    // Work out one instruction against the architectural state and advance it
    function automatic t_result execute_instr(input logic [7:0] op, input logic [7:0] lo,
                                              input logic [7:0] hi);
        t_result         res;
        logic [PC_W-1:0] length;
        logic            jumped;
        logic [15:0]     target;
        res    = '0;
        length = PC_W'(1);
        jumped = 1'b0;
        case (op)
            OP_CLD:     arch_flag_d = 1'b0;
            OP_SEI:     arch_flag_i = 1'b1;
            OP_LDX_IMM: begin
                arch_x = lo; arch_flag_z = (lo == 8'h00); length = PC_W'(2);
            end
            OP_LDY_IMM: begin
                arch_y = lo; arch_flag_z = (lo == 8'h00); length = PC_W'(2);
            end
            OP_LDA_IMM: begin
                arch_acc = lo; arch_flag_z = (lo == 8'h00); length = PC_W'(2);
            end
            OP_TXS:     arch_sp = arch_x;
            OP_TXA:     begin arch_acc = arch_x; arch_flag_z = (arch_acc == 8'h00); end
            OP_INX:     begin arch_x = arch_x + 8'd1; arch_flag_z = (arch_x == 8'h00); end
            OP_INY:     begin arch_y = arch_y + 8'd1; arch_flag_z = (arch_y == 8'h00); end
            OP_DEX:     begin arch_x = arch_x - 8'd1; arch_flag_z = (arch_x == 8'h00); end
            OP_DEY:     begin arch_y = arch_y - 8'd1; arch_flag_z = (arch_y == 8'h00); end
            OP_ASL_A:   begin arch_acc = arch_acc << 1; arch_flag_z = (arch_acc == 8'h00); end
            OP_STA_ZP: begin
                res.write_enable = 1'b1; res.write_address = lo;
                res.write_data = arch_acc; length = PC_W'(2);
            end
            OP_STA_ZPX: begin
                // indexed address wraps within the zero page
                res.write_enable = 1'b1; res.write_address = lo + arch_x;
                res.write_data = arch_acc; length = PC_W'(2);
            end
            OP_STX_ZP: begin
                res.write_enable = 1'b1; res.write_address = lo;
                res.write_data = arch_x; length = PC_W'(2);
            end
            OP_STY_ZP: begin
                res.write_enable = 1'b1; res.write_address = lo;
                res.write_data = arch_y; length = PC_W'(2);
            end
            OP_INC_ZP: begin
                res.write_enable = 1'b1; res.write_address = lo;
                res.write_data = arch_zp[lo] + 8'd1;
                arch_flag_z = (res.write_data == 8'h00); length = PC_W'(2);
            end
            OP_LDA_ZP: begin
                arch_acc = arch_zp[lo]; arch_flag_z = (arch_acc == 8'h00); length = PC_W'(2);
            end
            OP_CPX_IMM: begin arch_flag_z = (arch_x == lo); length = PC_W'(2); end
            OP_CPY_IMM: begin arch_flag_z = (arch_y == lo); length = PC_W'(2); end
            OP_BNE: begin
                length = PC_W'(2);
                if (!arch_flag_z) begin
                    // target is relative to the following instruction, offset signed
                    target  = 16'(arch_pc) + 16'd2 + {{8{lo[7]}}, lo};
                    arch_pc = PC_W'(target % ROM_BYTES);
                    jumped  = 1'b1;
                    n_taken++;
                end
            end
            OP_JMP_ABS: begin
                arch_pc = PC_W'({hi, lo} % ROM_BYTES);
                jumped  = 1'b1;
            end
            OP_NOP: ;
            default: begin
                res.illegal_opcode = 1'b1;
                n_illegal++;
            end
        endcase
        if (res.write_enable) begin
            arch_zp[res.write_address] = res.write_data;
            res.wsync_hit = (res.write_address == WSYNC_ADDR);
            if (res.wsync_hit)
                n_wsync++;
        end
        if (!res.illegal_opcode && !jumped)
            arch_pc = PC_W'((32'(arch_pc) + 32'(length)) % ROM_BYTES);
        res.next_pc   = arch_pc;
        res.acc_value = arch_acc;
        res.x_value   = arch_x;
        res.y_value   = arch_y;
        res.zero_flag = arch_flag_z;
        return res;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("pc=%03h we=%0b wa=%02h wd=%02h ws=%0b ill=%0b a=%02h x=%02h y=%02h z=%0b",
                         r.next_pc, r.write_enable, r.write_address, r.write_data, r.wsync_hit,
                         r.illegal_opcode, r.acc_value, r.x_value, r.y_value, r.zero_flag);
    endfunction

    // Offer one instruction, optionally after an idle burst, and hold it until transfer
    task automatic issue_instr(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_operand_low  <= lo;
        i_operand_high <= hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(execute_instr(op, lo, hi));
        n_issued++;
    endtask

    // Draw one instruction: mostly supported opcodes with operands steered at the
    // interesting corners, now and then a fully random byte
    task automatic pick_instr(output logic [7:0] op, output logic [7:0] lo,
                              output logic [7:0] hi);
        hi = 8'($urandom);
        lo = 8'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            op = 8'($urandom);
        end else begin
            op = LEGAL_OPS[$urandom_range(0, 22)];
            case (op)
                OP_STA_ZP, OP_STA_ZPX, OP_STX_ZP, OP_STY_ZP, OP_LDA_ZP, OP_INC_ZP: begin
                    // crowd accesses onto a few bytes so stores, reads and increments collide
                    case ($urandom_range(0, 3))
                        0:       lo = WSYNC_ADDR;
                        1, 2:    lo = 8'($urandom_range(0, 7));
                        default: ;
                    endcase
                end
                OP_LDX_IMM, OP_LDY_IMM, OP_LDA_IMM, OP_CPX_IMM, OP_CPY_IMM: begin
                    case ($urandom_range(0, 5))
                        0:       lo = 8'h00;
                        1:       lo = 8'hFF;
                        2:       lo = arch_x;
                        3:       lo = arch_y;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    endtask

    // Typical clear loop: fill a run of zero-page bytes counting X down to zero
    task automatic run_clear_loop();
        logic [7:0] base;
        logic [7:0] count;
        base  = 8'($urandom_range(0, 15));
        count = 8'($urandom_range(1, 8));
        issue_instr(OP_LDA_IMM, 8'($urandom), 8'($urandom));
        issue_instr(OP_LDX_IMM, count, 8'($urandom));
        repeat (count) begin
            issue_instr(OP_STA_ZPX, base, 8'($urandom));
            issue_instr(OP_DEX, 8'($urandom), 8'($urandom));
            issue_instr(OP_BNE, 8'hFB, 8'($urandom));
        end
        issue_instr(OP_LDA_ZP, base + count, 8'($urandom));
    endtask

    task automatic test_reset_state();
        issue_instr(8'h00, 8'h00, 8'h00);
        issue_instr(OP_NOP, 8'hFF, 8'hFF);
        issue_instr(8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_registers_and_flags();
        issue_instr(OP_LDA_IMM, 8'h00, 8'h00);
        issue_instr(OP_LDX_IMM, 8'hFF, 8'h00);
        issue_instr(OP_INX, 8'h00, 8'h00);
        issue_instr(OP_DEX, 8'h00, 8'h00);
        issue_instr(OP_TXA, 8'h00, 8'h00);
        issue_instr(OP_ASL_A, 8'h00, 8'h00);
        issue_instr(OP_LDA_IMM, 8'h80, 8'h00);
        issue_instr(OP_ASL_A, 8'h00, 8'h00);
        issue_instr(OP_TXS, 8'h00, 8'h00);
        issue_instr(OP_SEI, 8'h00, 8'h00);
        issue_instr(OP_CLD, 8'h00, 8'h00);
        issue_instr(OP_LDY_IMM, 8'h00, 8'h00);
        issue_instr(OP_DEY, 8'h00, 8'h00);
        issue_instr(OP_INY, 8'h00, 8'h00);
        issue_instr(OP_CPX_IMM, 8'hFF, 8'h00);
        issue_instr(OP_CPY_IMM, 8'h01, 8'h00);
    endtask

    task automatic test_zero_page();
        // X is FF here: the indexed store wraps back onto the wsync byte
        issue_instr(OP_STX_ZP, WSYNC_ADDR, 8'h00);
        issue_instr(OP_STA_ZPX, 8'h03, 8'h00);
        issue_instr(OP_INC_ZP, WSYNC_ADDR, 8'h00);
        issue_instr(OP_INC_ZP, WSYNC_ADDR, 8'h00);
        issue_instr(OP_LDA_ZP, WSYNC_ADDR, 8'h00);
        issue_instr(OP_STX_ZP, 8'hFF, 8'h00);
        issue_instr(OP_INC_ZP, 8'hFF, 8'h00);
        issue_instr(OP_STY_ZP, 8'h00, 8'h00);
    endtask

    task automatic test_program_flow();
        issue_instr(OP_JMP_ABS, 8'hFF, 8'hFF);
        issue_instr(OP_NOP, 8'h00, 8'h00);
        issue_instr(OP_LDX_IMM, 8'h01, 8'h00);
        issue_instr(OP_BNE, 8'h80, 8'h00);
        issue_instr(OP_LDX_IMM, 8'h00, 8'h00);
        issue_instr(OP_BNE, 8'h10, 8'h00);
        issue_instr(OP_JMP_ABS, 8'hFE, 8'h0F);
        issue_instr(OP_LDY_IMM, 8'h05, 8'h00);
        issue_instr(OP_BNE, 8'h7F, 8'h00);
    endtask

    task automatic test_random_mix(input int unsigned count);
        int unsigned stop_at;
        logic [7:0]  op;
        logic [7:0]  lo;
        logic [7:0]  hi;
        stop_at = n_issued + count;
        while (n_issued < stop_at) begin
            if ($urandom_range(0, 24) == 0) begin
                run_clear_loop();
            end else begin
                pick_instr(op, lo, hi);
                issue_instr(op, lo, hi);
            end
        end
    endtask

    // Hold the result side off for a long stretch while instructions keep coming
    task automatic test_result_backpressure();
        logic [7:0] op;
        logic [7:0] lo;
        logic [7:0] hi;
        sink_hold_req = 300;
        repeat (80) begin
            pick_instr(op, lo, hi);
            issue_instr(op, lo, hi);
        end
    endtask

    // Stop offering until every owed result is back, then carry on
    task automatic test_sender_pause();
        test_random_mix(20);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        test_random_mix(20);
    endtask

    // Result side: random stall bursts, plus the long hold-off when one is requested
    initial begin : result_sink
        int unsigned held;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req != 0) begin
                i_out_ready <= 1'b0;
                held = 0;
                while (held < sink_hold_req) begin
                    @(posedge i_clk);
                    held++;
                end
                sink_hold_req = 0;
                i_out_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Compare every result transfer with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        string   diffs;
        if (i_rst_n && i_in_valid && !o_in_ready)
            n_in_stalls++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.next_pc        = o_next_pc;
            got.write_enable   = o_write_enable;
            got.write_address  = o_write_address;
            got.write_data     = o_write_data;
            got.wsync_hit      = o_wsync_hit;
            got.illegal_opcode = o_illegal_opcode;
            got.acc_value      = o_acc_value;
            got.x_value        = o_x_value;
            got.y_value        = o_y_value;
            got.zero_flag      = o_zero_flag;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= REPORT_LIMIT)
                    $display("%0t: result with nothing owed: %s", $realtime, fmt_result(got));
            end else begin
                want  = pending_results.pop_front();
                diffs = "";
                if (got.next_pc !== want.next_pc)               diffs = {diffs, " next_pc"};
                if (got.write_enable !== want.write_enable)     diffs = {diffs, " write_enable"};
                if (got.write_address !== want.write_address)   diffs = {diffs, " write_address"};
                if (got.write_data !== want.write_data)         diffs = {diffs, " write_data"};
                if (got.wsync_hit !== want.wsync_hit)           diffs = {diffs, " wsync_hit"};
                if (got.illegal_opcode !== want.illegal_opcode) diffs = {diffs, " illegal_opcode"};
                if (got.acc_value !== want.acc_value)           diffs = {diffs, " acc_value"};
                if (got.x_value !== want.x_value)               diffs = {diffs, " x_value"};
                if (got.y_value !== want.y_value)               diffs = {diffs, " y_value"};
                if (got.zero_flag !== want.zero_flag)           diffs = {diffs, " zero_flag"};
                if (diffs.len() != 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_LIMIT) begin
                        $display("%0t: result %0d differs in%s", $realtime, n_retired, diffs);
                        $display("    expected %s", fmt_result(want));
                        $display("    actual   %s", fmt_result(got));
                    end
                end
            end
            n_retired++;
        end
    end

    initial begin : run_limit
        #15_000_000;
        $display("Run limit reached with %0d results owed", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : run_tests
        int unsigned guard;
        arch_acc    = 8'h00;
        arch_x      = 8'h00;
        arch_y      = 8'h00;
        arch_sp     = 8'h00;
        arch_flag_z = 1'b0;
        arch_flag_d = 1'b0;
        arch_flag_i = 1'b0;
        arch_pc     = '0;
        foreach (arch_zp[i])
            arch_zp[i] = 8'h00;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_registers_and_flags();
        test_zero_page();
        test_program_flow();
        test_random_mix(700);
        test_result_backpressure();
        test_sender_pause();
        test_random_mix(650);
        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        test_random_mix(300);
        i_in_valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("%0d results never arrived", pending_results.size());
        end
        // allow a stray late result to show up
        repeat (20) @(posedge i_clk);

        $display("Ran %0d instructions: %0d illegal, %0d taken branches, %0d wsync writes",
                 n_issued, n_illegal, n_taken, n_wsync);
        $display("Checked %0d results; input held back for %0d cycles", n_retired, n_in_stalls);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", n_errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
hdl/c6502s_pkg.sv
hdl/c6502s_zp_ram.sv
hdl/c6502s_exec.sv
hdl/cpu6502_subset_execute_core.sv
hdl/c6502s_checker.sv
tb/testbench.sv
